// ===== design/axdr_pkg.sv =====
// ----------------------------------------------------------------------------
// A-XDR stream decoder package
// Shared widths, result codes, tag codes and tag classification functions.
// ----------------------------------------------------------------------------
`default_nettype none

package axdr_pkg;

  localparam int LengthWidthDefault = 16;

  localparam int ByteW   = 8;
  localparam int KindW   = 3;
  localparam int ValueW  = 64;
  localparam int ExtraW  = 24;
  localparam int LenOutW = 16;
  localparam int StatusW = 2;
  localparam int CountW  = 4;

  typedef enum logic [KindW-1:0] {
    KIND_VALUE  = 3'd0,
    KIND_STRHDR = 3'd1,
    KIND_BYTE   = 3'd2,
    KIND_AGGHDR = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK     = 2'd0,
    STAT_SHORT  = 2'd1,
    STAT_PREFIX = 2'd2,
    STAT_UNSUP  = 2'd3
  } status_e;

  // Data type tags.
  localparam logic [ByteW-1:0] TAG_NULL      = 8'd0;
  localparam logic [ByteW-1:0] TAG_ARRAY     = 8'd1;
  localparam logic [ByteW-1:0] TAG_STRUCT    = 8'd2;
  localparam logic [ByteW-1:0] TAG_BOOLEAN   = 8'd3;
  localparam logic [ByteW-1:0] TAG_BITSTR    = 8'd4;
  localparam logic [ByteW-1:0] TAG_DLONG     = 8'd5;
  localparam logic [ByteW-1:0] TAG_DLONGU    = 8'd6;
  localparam logic [ByteW-1:0] TAG_OCTSTR    = 8'd9;
  localparam logic [ByteW-1:0] TAG_VISSTR    = 8'd10;
  localparam logic [ByteW-1:0] TAG_UTF8STR   = 8'd12;
  localparam logic [ByteW-1:0] TAG_BCD       = 8'd13;
  localparam logic [ByteW-1:0] TAG_INTEGER   = 8'd15;
  localparam logic [ByteW-1:0] TAG_LONG      = 8'd16;
  localparam logic [ByteW-1:0] TAG_UNSIGNED  = 8'd17;
  localparam logic [ByteW-1:0] TAG_LONGU     = 8'd18;
  localparam logic [ByteW-1:0] TAG_COMPACT   = 8'd19;
  localparam logic [ByteW-1:0] TAG_LONG64    = 8'd20;
  localparam logic [ByteW-1:0] TAG_LONG64U   = 8'd21;
  localparam logic [ByteW-1:0] TAG_ENUM      = 8'd22;
  localparam logic [ByteW-1:0] TAG_FLOAT32   = 8'd23;
  localparam logic [ByteW-1:0] TAG_FLOAT64   = 8'd24;
  localparam logic [ByteW-1:0] TAG_DATETIME  = 8'd25;
  localparam logic [ByteW-1:0] TAG_DATE      = 8'd26;
  localparam logic [ByteW-1:0] TAG_TIME      = 8'd27;
  localparam logic [ByteW-1:0] TAG_DONTCARE  = 8'd255;

  // Byte positions inside a date-time field.
  localparam logic [CountW-1:0] DtDayOfWeekPos = 4'd4;
  localparam logic [CountW-1:0] DtExtraPos     = 4'd9;

  // Long-form length prefix markers.
  localparam logic [ByteW-1:0] PrefixLongMask  = 8'h80;
  localparam logic [ByteW-1:0] PrefixCountMask = 8'h0F;

  // Number of field bytes after the tag for fixed-size types, zero otherwise.
  function automatic logic [CountW-1:0] fixed_size(input logic [ByteW-1:0] t);
    logic [CountW-1:0] sz;
    case (t)
      TAG_BOOLEAN, TAG_INTEGER, TAG_UNSIGNED, TAG_ENUM: sz = 4'd1;
      TAG_LONG, TAG_LONGU:                              sz = 4'd2;
      TAG_DLONG, TAG_DLONGU, TAG_FLOAT32, TAG_TIME:     sz = 4'd4;
      TAG_DATE:                                         sz = 4'd5;
      TAG_LONG64, TAG_LONG64U, TAG_FLOAT64:             sz = 4'd8;
      TAG_DATETIME:                                     sz = 4'd12;
      default:                                          sz = 4'd0;
    endcase
    return sz;
  endfunction

  function automatic logic is_string(input logic [ByteW-1:0] t);
    return (t == TAG_BITSTR) || (t == TAG_OCTSTR) || (t == TAG_VISSTR) ||
           (t == TAG_UTF8STR) || (t == TAG_BCD) || (t == TAG_COMPACT);
  endfunction

endpackage

`default_nettype wire

// ===== design/axdr_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// A-XDR stream decoder
// Parses an A-XDR encoded byte stream, one word per cycle unless the output
// stalls, into value, header, payload byte and error results.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_ready_o) takes one encoded byte per
//   word, with buffer_end_i marking the final byte of a buffer. The output
//   channel (out_valid_o / out_ready_i) delivers at most one result word per
//   input word: a completed fixed-size value, a string or aggregate header,
//   one payload byte, or an error. Input bytes that only extend a field or a
//   length prefix give no result.
//   Throughput is one byte per cycle while the receiver takes results. Each
//   byte is decoded by the state and a single layer of logic straight into
//   the result register, so a result shows in the cycle after acceptance.
//   The result register is the only buffer between the two sides: while it
//   holds a word the receiver has not taken, a new byte is accepted only in a
//   cycle in which out_ready_i is high, so a stalled receiver stalls the
//   input after at most one pending result.
//   Reset returns the parser to waiting for a tag and empties the result
//   register. Any error also returns the parser to waiting for a tag.
// ----------------------------------------------------------------------------
`default_nettype none

module axdr_stream_decoder #(
  parameter int LENGTH_WIDTH = axdr_pkg::LengthWidthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [axdr_pkg::ByteW-1:0]   byte_in_i,
  input  wire logic                         buffer_end_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [axdr_pkg::KindW-1:0]        kind_o,
  output logic [axdr_pkg::ByteW-1:0]        tag_o,
  output logic [axdr_pkg::ValueW-1:0]       value_o,
  output logic [axdr_pkg::ExtraW-1:0]       extra_o,
  output logic [axdr_pkg::LenOutW-1:0]      length_o,
  output logic [axdr_pkg::StatusW-1:0]      status_o,
  output logic                              item_last_o
);

  import axdr_pkg::*;

  // A length prefix may carry up to LENGTH_WIDTH/8 further bytes.
  localparam int MaxPrefix = LENGTH_WIDTH / 8;
  localparam int PreW      = $clog2(MaxPrefix + 1);
  localparam int WideW     = 32;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_FIXED,
    PH_PREFIX,
    PH_PREFIX_MORE,
    PH_PAYLOAD
  } phase_e;

  // Parser state.
  phase_e                  phase_q, phase_d;
  logic [ByteW-1:0]        tag_q, tag_d;
  logic [ValueW-1:0]       acc_q, acc_d;
  logic [ExtraW-1:0]       ext_q, ext_d;
  logic [CountW-1:0]       btg_q, btg_d;
  logic [PreW-1:0]         pre_cnt_q, pre_cnt_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;

  // Result of the byte currently offered.
  logic               res_valid;
  kind_e              res_kind;
  logic [ValueW-1:0]  res_value;
  logic [ExtraW-1:0]  res_extra;
  logic [LenOutW-1:0] res_length;
  status_e            res_status;
  logic               res_last;

  // Output register.
  logic               out_valid_q;
  kind_e              kind_q;
  logic [ByteW-1:0]   tag_out_q;
  logic [ValueW-1:0]  value_q;
  logic [ExtraW-1:0]  extra_q;
  logic [LenOutW-1:0] length_q;
  status_e            status_q;
  logic               last_q;

  // Decode helpers.
  logic                    in_fire;
  logic [CountW-1:0]       tag_size;
  logic [CountW-1:0]       cur_size;
  logic [CountW-1:0]       pos;
  logic [CountW-1:0]       prefix_n;
  logic                    len_done;
  logic [LENGTH_WIDTH-1:0] len_val;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign tag_size = fixed_size(byte_in_i);
  assign cur_size = fixed_size(tag_q);
  assign pos      = cur_size - btg_q;
  assign prefix_n = CountW'(byte_in_i & PrefixCountMask);

  always_comb begin
    phase_d    = phase_q;
    tag_d      = tag_q;
    acc_d      = acc_q;
    ext_d      = ext_q;
    btg_d      = btg_q;
    pre_cnt_d  = pre_cnt_q;
    len_d      = len_q;
    rem_d      = rem_q;
    res_valid  = 1'b0;
    res_kind   = KIND_VALUE;
    res_value  = '0;
    res_extra  = '0;
    res_length = '0;
    res_status = STAT_OK;
    res_last   = 1'b0;
    len_done   = 1'b0;
    len_val    = '0;

    case (phase_q)
      PH_TAG: begin
        tag_d = byte_in_i;
        acc_d = '0;
        ext_d = '0;
        if (byte_in_i == TAG_NULL || byte_in_i == TAG_DONTCARE) begin
          res_valid = 1'b1;
          res_last  = 1'b1;
        end else if (tag_size != '0) begin
          if (buffer_end_i) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_status = STAT_SHORT;
            res_last   = 1'b1;
          end else begin
            btg_d   = tag_size;
            phase_d = PH_FIXED;
          end
        end else if (is_string(byte_in_i) || byte_in_i == TAG_ARRAY ||
                     byte_in_i == TAG_STRUCT) begin
          if (buffer_end_i) begin
            res_valid  = 1'b1;
            res_kind   = KIND_ERROR;
            res_status = STAT_SHORT;
            res_last   = 1'b1;
          end else begin
            phase_d = PH_PREFIX;
          end
        end else begin
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_UNSUP;
          res_last   = 1'b1;
        end
      end

      PH_FIXED: begin
        // Date-time: the day-of-week byte is dropped and the last three bytes
        // (deviation and clock status) go to the extra field.
        if (tag_q == TAG_DATETIME && pos >= DtExtraPos) begin
          ext_d = {ext_q[ExtraW-ByteW-1:0], byte_in_i};
        end else if (!(tag_q == TAG_DATETIME && pos == DtDayOfWeekPos)) begin
          acc_d = {acc_q[ValueW-ByteW-1:0], byte_in_i};
        end
        btg_d = btg_q - CountW'(1);
        if (btg_q == CountW'(1)) begin
          phase_d   = PH_TAG;
          res_valid = 1'b1;
          res_value = (tag_q == TAG_BOOLEAN) ? ValueW'(acc_d != '0) : acc_d;
          res_extra = ext_d;
          res_last  = 1'b1;
        end else if (buffer_end_i) begin
          phase_d    = PH_TAG;
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_SHORT;
          res_last   = 1'b1;
        end
      end

      PH_PREFIX: begin
        if ((byte_in_i & PrefixLongMask) == '0) begin
          len_done = 1'b1;
          len_val  = LENGTH_WIDTH'(byte_in_i);
        end else if (prefix_n == '0 || prefix_n > CountW'(MaxPrefix) ||
                     buffer_end_i) begin
          phase_d    = PH_TAG;
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_PREFIX;
          res_last   = 1'b1;
        end else begin
          pre_cnt_d = PreW'(prefix_n);
          len_d     = '0;
          phase_d   = PH_PREFIX_MORE;
        end
      end

      PH_PREFIX_MORE: begin
        len_d     = LENGTH_WIDTH'({len_q, byte_in_i});
        pre_cnt_d = pre_cnt_q - PreW'(1);
        if (pre_cnt_q == PreW'(1)) begin
          len_done = 1'b1;
          len_val  = len_d;
        end else if (buffer_end_i) begin
          phase_d    = PH_TAG;
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_PREFIX;
          res_last   = 1'b1;
        end
      end

      PH_PAYLOAD: begin
        rem_d = rem_q - LENGTH_WIDTH'(1);
        if (rem_q == LENGTH_WIDTH'(1)) begin
          phase_d   = PH_TAG;
          res_valid = 1'b1;
          res_kind  = KIND_BYTE;
          res_value = ValueW'(byte_in_i);
          res_last  = 1'b1;
        end else if (buffer_end_i) begin
          phase_d    = PH_TAG;
          res_valid  = 1'b1;
          res_kind   = KIND_ERROR;
          res_status = STAT_SHORT;
          res_last   = 1'b1;
        end else begin
          res_valid = 1'b1;
          res_kind  = KIND_BYTE;
          res_value = ValueW'(byte_in_i);
        end
      end

      default: begin
        phase_d = PH_TAG;
      end
    endcase

    // A completed length or count turns into a header, or into an error if the buffer ends before a string's payload.
    if (len_done) begin
      res_valid = 1'b1;
      if (!is_string(tag_q)) begin
        phase_d    = PH_TAG;
        res_kind   = KIND_AGGHDR;
        res_length = LenOutW'(WideW'(len_val));
        res_last   = 1'b1;
      end else if (len_val == '0) begin
        phase_d  = PH_TAG;
        res_kind = KIND_STRHDR;
        res_last = 1'b1;
      end else if (buffer_end_i) begin
        phase_d    = PH_TAG;
        res_kind   = KIND_ERROR;
        res_status = STAT_SHORT;
        res_last   = 1'b1;
      end else begin
        rem_d      = len_val;
        phase_d    = PH_PAYLOAD;
        res_kind   = KIND_STRHDR;
        res_length = LenOutW'(WideW'(len_val));
      end
    end
  end

  // Parser state advances on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TAG;
      tag_q     <= '0;
      acc_q     <= '0;
      ext_q     <= '0;
      btg_q     <= '0;
      pre_cnt_q <= '0;
      len_q     <= '0;
      rem_q     <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      tag_q     <= tag_d;
      acc_q     <= acc_d;
      ext_q     <= ext_d;
      btg_q     <= btg_d;
      pre_cnt_q <= pre_cnt_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

  // Result register: emptied when taken, refilled by an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      kind_q    <= res_kind;
      tag_out_q <= tag_d;
      value_q   <= res_value;
      extra_q   <= res_extra;
      length_q  <= res_length;
      status_q  <= res_status;
      last_q    <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign tag_o       = tag_out_q;
  assign value_o     = value_q;
  assign extra_o     = extra_q;
  assign length_o    = length_q;
  assign status_o    = status_q;
  assign item_last_o = last_q;

endmodule

`default_nettype wire
